[hw/rtl/sba_pkg.sv]
package sba_pkg;

    localparam int ADDR_W      = 19;
    localparam int SIZE_W      = 12;
    localparam int BITMAP_BITS = 256;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 9;
    localparam int PAGE_W      = 9;
    localparam int CLASS_W     = 3;
    localparam int STATUS_W    = 3;
    localparam int MAX_CLASS_BYTES = 2048;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_SLAB   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 3'd4;

    typedef enum logic [1:0] {
        CMD_ALLOC,
        CMD_FREE,
        CMD_ERR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [STATUS_W-1:0]   status;
        logic [CLASS_W-1:0]    ci;
        logic [PAGE_W-1:0]     page;
        logic [SLOT_W-1:0]     slot;
        logic [CNT_W-1:0]      slots;
        logic [CNT_W-1:0]      base;
    } cmd_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_DEC,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_CHECK,
        B_FREE,
        B_FREE_CHK,
        B_OUT
    } back_state_t;

endpackage

[hw/rtl/slab_bitmap_allocator.sv]
// channel | dir | tdata fields (low bit up)                         | tuser
// s_      | in  | opcode[0], request_size[12:1], free_address[31:13] | -
// m_      | out | status[2:0], slot_address[21:3], slab_released[22] | -
// Free: accept, 2 divide steps (reciprocal multiply, then correction),
// decode and push, then the executor's B_FREE, B_FREE_CHK and B_OUT states.
// Allocate: a B_SCAN and a B_CHECK on one bitmap memory read per active slab
// of the class until a free slot is found, a B_SCAN per inactive slab, then a write.
// Reset clears slab active flags; bitmap rows are rewritten on activation.
// A stalled m_ side holds the executor; the front keeps taking words into
// a two-entry command queue until the queue is full.
module slab_bitmap_allocator #(
    parameter int NUM_CLASSES     = 8,
    parameter int SLABS_PER_CLASS = 16,
    parameter int PAGE_BYTES      = 4096,
    parameter int HEADER_BYTES    = 28
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode, request_size, free_address
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, slot_address, slab_released, pad
);
    import sba_pkg::*;

    cmd_t                push_cmd, head;
    logic                push, full, pop, empty;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   slot_address;
    logic                slab_released;

    sba_front #(
        .NUM_CLASSES    (NUM_CLASSES),
        .SLABS_PER_CLASS(SLABS_PER_CLASS),
        .PAGE_BYTES     (PAGE_BYTES),
        .HEADER_BYTES   (HEADER_BYTES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (full)
    );

    sba_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .full    (full),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    sba_back #(
        .NUM_CLASSES    (NUM_CLASSES),
        .SLABS_PER_CLASS(SLABS_PER_CLASS),
        .PAGE_BYTES     (PAGE_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .status       (status),
        .slot_address (slot_address),
        .slab_released(slab_released)
    );

    assign m_tdata = {1'b0, slab_released, slot_address, status};

    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status != ST_OK) |-> (slot_address == '0))
        else $error("address on failed word");

    a_rel_is_free: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && slab_released |-> (status == ST_OK) && (slot_address == '0))
        else $error("release flag on non-free word");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue overflow");

endmodule

[hw/rtl/sba_front.sv]
module sba_front #(
    parameter int NUM_CLASSES     = 8,
    parameter int SLABS_PER_CLASS = 16,
    parameter int PAGE_BYTES      = 4096,
    parameter int HEADER_BYTES    = 28
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,
    output logic                      push,
    output sba_pkg::cmd_t             push_cmd,
    input  logic                      full
);
    import sba_pkg::*;

    localparam int NUM_PAGES = NUM_CLASSES * SLABS_PER_CLASS;
    localparam int QMAX = ((1 << ADDR_W) - 1) / PAGE_BYTES;
    localparam int QW   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
    // page = addr / PAGE_BYTES by reciprocal multiply, off by at most one
    localparam longint RECIP = (64'd1 << 32) / PAGE_BYTES;
    localparam int RW   = $clog2(RECIP + 1);
    localparam int PRW  = ADDR_W + RW;

    logic [CNT_W-1:0] slots_tab [NUM_CLASSES];
    logic [CNT_W-1:0] base_tab  [NUM_CLASSES];

    for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_tab
        localparam longint SS   = 64'd16 << c;
        localparam longint AV   = longint'(PAGE_BYTES - HEADER_BYTES);
        localparam longint PAY  = AV * (8 * SS) / (8 * SS + 1);
        localparam longint SL   = PAY / SS;
        localparam longint SLC  = (SL > BITMAP_BITS) ? BITMAP_BITS : SL;
        localparam longint BS   = HEADER_BYTES + (SLC + 7) / 8;
        assign slots_tab[c] = CNT_W'(SLC);
        assign base_tab[c]  = CNT_W'(BS);
    end

    front_state_t      state_reg, state_next;
    logic              op_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [QW-1:0]     q_reg, q_next;
    logic              k_reg, k_next;
    cmd_t              cmd_reg, cmd_next;

    logic [PRW-1:0]    prod;
    logic [31:0]       qd, rr;
    logic [CLASS_W-1:0] aci, fci;
    logic [SIZE_W-1:0]  sm1;
    logic [16:0]        rel;
    logic [16:0]        slot_full;
    logic [PAGE_W-1:0]  fpage;
    logic               big;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        k_reg   <= k_next;
        cmd_reg <= cmd_next;
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tdata[0];
            size_reg <= s_tdata[12:1];
        end
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        k_next     = k_reg;
        cmd_next   = cmd_reg;
        s_tready   = (state_reg == F_IDLE);
        push       = 1'b0;
        push_cmd   = cmd_reg;

        prod = PRW'(rem_reg) * PRW'(RECIP);
        qd   = 32'(q_reg) * 32'(PAGE_BYTES);
        rr   = 32'(rem_reg) - qd;

        sm1 = size_reg - SIZE_W'(1);
        aci = '0;
        big = 1'b1;
        for (int c = 7; c >= 0; c--) begin
            if ((sm1 >> (c + 4)) == '0) begin
                aci = CLASS_W'(c);
                big = 1'b0;
            end
        end

        fpage = PAGE_W'(q_reg);
        fci   = '0;
        for (int c = 1; c < NUM_CLASSES; c++) begin
            if (32'(q_reg) >= 32'(c * SLABS_PER_CLASS)) fci = CLASS_W'(c);
        end
        rel       = 17'(rem_reg) - 17'(base_tab[fci]);
        slot_full = rel >> (4 + fci);

        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    rem_next = s_tdata[31:13];
                    q_next   = '0;
                    k_next   = 1'b1;
                    state_next = s_tdata[0] ? F_DIV : F_DEC;
                end
            end
            F_DIV: begin
                if (k_reg) begin
                    q_next = QW'(prod >> 32);
                    k_next = 1'b0;
                end else begin
                    if (rr >= 32'(PAGE_BYTES)) begin
                        q_next   = q_reg + QW'(1);
                        rem_next = ADDR_W'(rr - 32'(PAGE_BYTES));
                    end else begin
                        rem_next = ADDR_W'(rr);
                    end
                    state_next = F_DEC;
                end
            end
            F_DEC: begin
                cmd_next = '0;
                if (!op_reg) begin
                    cmd_next.kind  = CMD_ALLOC;
                    cmd_next.ci    = aci;
                    cmd_next.slots = slots_tab[aci];
                    cmd_next.base  = base_tab[aci];
                    if (size_reg == '0) begin
                        cmd_next.kind   = CMD_ERR;
                        cmd_next.status = ST_ZERO_SIZE;
                    end else if (32'(size_reg) > MAX_CLASS_BYTES || big ||
                                 32'(aci) >= NUM_CLASSES) begin
                        cmd_next.kind   = CMD_ERR;
                        cmd_next.status = ST_TOO_LARGE;
                    end else if (slots_tab[aci] == '0) begin
                        cmd_next.kind   = CMD_ERR;
                        cmd_next.status = ST_NO_SLAB;
                    end
                end else begin
                    cmd_next.kind   = CMD_FREE;
                    cmd_next.ci     = fci;
                    cmd_next.page   = fpage;
                    cmd_next.slot   = SLOT_W'(slot_full);
                    if (32'(q_reg) >= NUM_PAGES ||
                        17'(rem_reg) < 17'(base_tab[fci]) ||
                        (rel & ((17'd16 << fci) - 17'd1)) != '0 ||
                        slot_full >= 17'(slots_tab[fci])) begin
                        cmd_next.kind   = CMD_ERR;
                        cmd_next.status = ST_BAD_FREE;
                    end
                end
                state_next = F_PUSH;
            end
            F_PUSH: begin
                if (!full) begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

endmodule

[hw/rtl/sba_queue.sv]
module sba_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sba_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output sba_pkg::cmd_t head
);
    import sba_pkg::*;

    cmd_t       slot_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign head  = slot_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) wp_reg <= ~wp_reg;
            if (pop && !empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
        if (push && !full) slot_reg[wp_reg] <= push_cmd;
    end

endmodule

[hw/rtl/sba_back.sv]
module sba_back #(
    parameter int NUM_CLASSES     = 8,
    parameter int SLABS_PER_CLASS = 16,
    parameter int PAGE_BYTES      = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          empty,
    input  sba_pkg::cmd_t                 head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sba_pkg::STATUS_W-1:0]  status,
    output logic [sba_pkg::ADDR_W-1:0]    slot_address,
    output logic                          slab_released
);
    import sba_pkg::*;

    localparam int NP = NUM_CLASSES * SLABS_PER_CLASS;
    localparam int PW = (NP > 1) ? $clog2(NP) : 1;
    localparam int SW = $clog2(SLABS_PER_CLASS + 1);

    logic [BITMAP_BITS-1:0] mem [NP];
    logic [BITMAP_BITS-1:0] rd_data_reg;
    logic                   rd_en;
    logic [PW-1:0]          rd_addr;
    logic                   wr_en;
    logic [PW-1:0]          wr_addr;
    logic [BITMAP_BITS-1:0] wr_data;

    logic [NP-1:0]          active_reg, active_next;
    back_state_t            state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [SW-1:0]          s_reg, s_next;
    logic                   ifound_reg, ifound_next;
    logic [SW-1:0]          is_reg, is_next;
    logic [STATUS_W-1:0]    st_reg, st_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic                   rel_reg, rel_next;

    logic [PW-1:0]          cur_page, ina_page;
    logic [BITMAP_BITS-1:0] freemask, clr;
    logic [SLOT_W-1:0]      fb;
    logic                   any_free;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PW-1:0] pg,
                                                   input logic [CNT_W-1:0] bs,
                                                   input logic [SLOT_W-1:0] b,
                                                   input logic [CLASS_W-1:0] c);
        logic [31:0] a;
        a = 32'(pg) * 32'(PAGE_BYTES) + 32'(bs) + (32'(b) << (4 + c));
        return a[ADDR_W-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (rd_en) rd_data_reg <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= B_IDLE;
            active_reg <= '0;
        end else begin
            state_reg  <= state_next;
            active_reg <= active_next;
        end
        cmd_reg    <= cmd_next;
        s_reg      <= s_next;
        ifound_reg <= ifound_next;
        is_reg     <= is_next;
        st_reg     <= st_next;
        addr_reg   <= addr_next;
        rel_reg    <= rel_next;
    end

    assign m_tvalid      = (state_reg == B_OUT);
    assign status        = st_reg;
    assign slot_address  = addr_reg;
    assign slab_released = rel_reg;

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        cmd_next    = cmd_reg;
        s_next      = s_reg;
        ifound_next = ifound_reg;
        is_next     = is_reg;
        st_next     = st_reg;
        addr_next   = addr_reg;
        rel_next    = rel_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;

        cur_page = PW'(32'(cmd_reg.ci) * SLABS_PER_CLASS + 32'(s_reg));
        ina_page = PW'(32'(cmd_reg.ci) * SLABS_PER_CLASS + 32'(is_reg));

        for (int i = 0; i < BITMAP_BITS; i++) begin
            freemask[i] = ~rd_data_reg[i] && (i < 32'(cmd_reg.slots));
        end
        fb       = '0;
        any_free = |freemask;
        for (int i = BITMAP_BITS - 1; i >= 0; i--) begin
            if (freemask[i]) fb = SLOT_W'(i);
        end
        clr = rd_data_reg & ~(BITMAP_BITS'(1) << cmd_reg.slot);

        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop         = 1'b1;
                    cmd_next    = head;
                    s_next      = '0;
                    ifound_next = 1'b0;
                    st_next     = ST_OK;
                    addr_next   = '0;
                    rel_next    = 1'b0;
                    case (head.kind)
                        CMD_ALLOC: state_next = B_SCAN;
                        CMD_FREE:  state_next = B_FREE;
                        default: begin
                            st_next    = head.status;
                            state_next = B_OUT;
                        end
                    endcase
                end
            end
            B_SCAN: begin
                if (32'(s_reg) == SLABS_PER_CLASS) begin
                    if (ifound_reg) begin
                        active_next[ina_page] = 1'b1;
                        wr_en     = 1'b1;
                        wr_addr   = ina_page;
                        wr_data   = BITMAP_BITS'(1);
                        addr_next = slot_addr(ina_page, cmd_reg.base, '0, cmd_reg.ci);
                    end else begin
                        st_next = ST_NO_SLAB;
                    end
                    state_next = B_OUT;
                end else if (active_reg[cur_page]) begin
                    rd_en      = 1'b1;
                    rd_addr    = cur_page;
                    state_next = B_CHECK;
                end else begin
                    if (!ifound_reg) begin
                        ifound_next = 1'b1;
                        is_next     = s_reg;
                    end
                    s_next = s_reg + SW'(1);
                end
            end
            B_CHECK: begin
                if (any_free) begin
                    wr_en      = 1'b1;
                    wr_addr    = cur_page;
                    wr_data    = rd_data_reg | (BITMAP_BITS'(1) << fb);
                    addr_next  = slot_addr(cur_page, cmd_reg.base, fb, cmd_reg.ci);
                    state_next = B_OUT;
                end else begin
                    s_next     = s_reg + SW'(1);
                    state_next = B_SCAN;
                end
            end
            B_FREE: begin
                if (!active_reg[PW'(cmd_reg.page)]) begin
                    st_next    = ST_BAD_FREE;
                    state_next = B_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = PW'(cmd_reg.page);
                    state_next = B_FREE_CHK;
                end
            end
            B_FREE_CHK: begin
                if (!rd_data_reg[cmd_reg.slot]) begin
                    st_next = ST_BAD_FREE;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = PW'(cmd_reg.page);
                    wr_data = clr;
                    if (clr == '0) begin
                        active_next[PW'(cmd_reg.page)] = 1'b0;
                        rel_next = 1'b1;
                    end
                end
                state_next = B_OUT;
            end
            B_OUT: begin
                if (m_tready) state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

endmodule

[tb/tb_slab_bitmap_allocator.sv]
module tb_slab_bitmap_allocator;
    import sba_pkg::*;

    localparam int NCLS = 8;
    localparam int NSLAB = 16;
    localparam int PAGE = 4096;
    localparam int HDR = 28;
    localparam int LIMIT = 20000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic        released;
        logic [18:0] addr;
        logic [2:0]  status;
    } alloc_result_t;

    class slab_scoreboard;
        logic [255:0] bitmaps [NCLS*NSLAB];
        logic [NSLAB-1:0] active [NCLS];
        alloc_result_t pending[$];
        int errors;

        function new();
            for (int p = 0; p < NCLS*NSLAB; p++) bitmaps[p] = '0;
            for (int c = 0; c < NCLS; c++) active[c] = '0;
            errors = 0;
        endfunction

        function int slots_of(int ci);
            longint ss;
            longint pay;
            longint n;
            ss = 64'd16 << ci;
            pay = longint'(PAGE - HDR) * (8 * ss) / (8 * ss + 1);
            n = pay / ss;
            if (n > 256) n = 256;
            return int'(n);
        endfunction

        function int base_of(int ci);
            return HDR + (slots_of(ci) + 7) / 8;
        endfunction

        function void note_word(logic op, logic [11:0] size, logic [18:0] fa);
            alloc_result_t r;
            int ci;
            int n;
            int page;
            int s;
            int off;
            int rel;
            int slot;
            bit done;
            r = '0;
            done = 0;
            if (op == OP_ALLOC) begin
                if (size == 0) begin
                    r.status = ST_ZERO_SIZE;
                end else if (size > MAX_CLASS_BYTES) begin
                    r.status = ST_TOO_LARGE;
                end else begin
                    ci = 0;
                    while (ci < 8 && ((int'(size) - 1) >> (ci + 4)) != 0) ci++;
                    n = slots_of(ci);
                    for (s = 0; s < NSLAB && !done; s++) begin
                        if (active[ci][s]) begin
                            page = ci * NSLAB + s;
                            for (int b = 0; b < n && !done; b++) begin
                                if (!bitmaps[page][b]) begin
                                    bitmaps[page][b] = 1'b1;
                                    r.addr = 19'(page * PAGE + base_of(ci) + b * (16 << ci));
                                    done = 1;
                                end
                            end
                        end
                    end
                    for (s = 0; s < NSLAB && !done; s++) begin
                        if (!active[ci][s]) begin
                            page = ci * NSLAB + s;
                            active[ci][s] = 1'b1;
                            bitmaps[page] = 256'd1;
                            r.addr = 19'(page * PAGE + base_of(ci));
                            done = 1;
                        end
                    end
                    if (!done) r.status = ST_NO_SLAB;
                end
            end else begin
                r.status = ST_BAD_FREE;
                page = int'(fa) / PAGE;
                off = int'(fa) % PAGE;
                if (page < NCLS * NSLAB) begin
                    ci = page / NSLAB;
                    s = page % NSLAB;
                    n = slots_of(ci);
                    if (active[ci][s] && off >= base_of(ci)) begin
                        rel = off - base_of(ci);
                        slot = rel / (16 << ci);
                        if (rel % (16 << ci) == 0 && slot < n && bitmaps[page][slot]) begin
                            bitmaps[page][slot] = 1'b0;
                            r.status = ST_OK;
                            if (bitmaps[page] == '0) begin
                                active[ci][s] = 1'b0;
                                r.released = 1'b1;
                            end
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_word(alloc_result_t got);
            alloc_result_t exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st=%0d a=%h r=%b got st=%0d a=%h r=%b",
                             exp.status, exp.addr, exp.released,
                             got.status, got.addr, got.released);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;

    slab_scoreboard sb;
    logic [18:0] granted[$];
    int idle_cycles = 0;
    bit quiet = 0;
    bit hold_off = 0;

    always #2 aclk = ~aclk;

    slab_bitmap_allocator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                sb.check_word(alloc_result_t'(m_tdata[22:0]));
                if (m_tdata[2:0] == ST_OK && m_tdata[21:3] != 0)
                    granted.push_back(m_tdata[21:3]);
            end
            if (idle_cycles > LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // s_tvalid stays up after an accept until the next call or drain() sets it
    task automatic send_word(logic op, logic [11:0] size, logic [18:0] fa);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {fa, size, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, size, fa);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic free_granted();
        int i;
        logic [18:0] a;
        if (granted.size() == 0) begin
            send_word(OP_FREE, 12'($urandom), 19'($urandom));
            return;
        end
        i = $urandom_range(0, granted.size() - 1);
        a = granted[i];
        granted.delete(i);
        send_word(OP_FREE, 12'($urandom), a);
    endtask

    task automatic random_word();
        int k;
        logic [11:0] sz;
        k = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: sz = 12'($urandom_range(1, 64));
            1: sz = 12'($urandom_range(1, 2048));
            2: sz = 12'($urandom_range(1, 256));
            default: sz = 12'($urandom);
        endcase
        if (k < 50) send_word(OP_ALLOC, sz, 19'($urandom));
        else if (k < 92) free_granted();
        else send_word(OP_FREE, 12'($urandom), 19'($urandom));
    endtask

    initial begin
        logic [11:0] sizes[10] = '{12'd0, 12'd1, 12'd16, 12'd17, 12'd2048, 12'd2049,
                                    12'd4095, 12'd1024, 12'd129, 12'd600};
        sb = new();
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (sizes[i]) send_word(OP_ALLOC, sizes[i], 19'h7FFFF);
        send_word(OP_FREE, 12'hFFF, 19'h7FFFF);
        send_word(OP_FREE, 12'd0, 19'd0);
        send_word(OP_FREE, 12'd0, 19'd60);
        send_word(OP_FREE, 12'd0, 19'd61);
        send_word(OP_FREE, 12'd0, 19'h3F);
        drain();
        for (int i = 0; i < 6; i++) free_granted();
        drain();
        // free the same slot twice
        send_word(OP_ALLOC, 12'd40, '0);
        drain();
        if (granted.size() != 0) begin
            send_word(OP_FREE, '0, granted[$]);
            send_word(OP_FREE, '0, granted.pop_back());
        end
        drain();

        hold_off = 1;
        for (int i = 0; i < 40; i++) random_word();
        drain();

        // exhaust the 2048-byte class (16 slabs, one slot each)
        for (int i = 0; i < 18; i++) send_word(OP_ALLOC, 12'd2000, '0);
        drain();

        for (int i = 0; i < 1000; i++) random_word();
        quiet = 1;
        for (int i = 0; i < 200; i++) random_word();
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
